>>> hw/rtl/bscmr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bscmr_pkg
// Shared types, codes and the character class test for the byte stream
// class match and replace block.
// ----------------------------------------------------------------------------
package bscmr_pkg;

	// Commands on the input channel.
	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_END  = 2'd1;
	localparam logic [1:0] CMD_PAT  = 2'd2;
	localparam logic [1:0] CMD_REP  = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_MATCH  = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_PATTERN_LENGTH   = 3'd0;
	localparam logic [2:0] CFG_REPLACE_LENGTH   = 3'd1;
	localparam logic [2:0] CFG_REPLACE_ENABLE   = 3'd2;
	localparam logic [2:0] CFG_CASE_INSENSITIVE = 3'd3;
	localparam logic [2:0] CFG_REGION_FIRST     = 3'd4;
	localparam logic [2:0] CFG_REGION_LENGTH    = 3'd5;

	// Class selectors, taken from the upper four bits of a class code.
	localparam logic [3:0] CLS_LITERAL = 4'd0;
	localparam logic [3:0] CLS_ALNUM   = 4'd1;
	localparam logic [3:0] CLS_ALPHA   = 4'd2;
	localparam logic [3:0] CLS_BLANK   = 4'd3;
	localparam logic [3:0] CLS_CNTRL   = 4'd4;
	localparam logic [3:0] CLS_DIGIT   = 4'd5;
	localparam logic [3:0] CLS_GRAPH   = 4'd6;
	localparam logic [3:0] CLS_PRINT   = 4'd7;
	localparam logic [3:0] CLS_LOWER   = 4'd8;
	localparam logic [3:0] CLS_UPPER   = 4'd9;
	localparam logic [3:0] CLS_LETTER  = 4'd10;
	localparam logic [3:0] CLS_PUNCT   = 4'd11;
	localparam logic [3:0] CLS_SPACE   = 4'd12;
	localparam logic [3:0] CLS_XDIGIT  = 4'd13;
	localparam logic [3:0] CLS_ANY     = 4'd14;

	// Control broadcast from the sequencer to every cell of the chain.
	typedef struct packed {
		logic       shift;
		logic [7:0] wbyte;
		logic [7:0] pbyte;
		logic [4:0] pcode;
		logic       case_ins;
	} cell_ctrl_t;

	function automatic logic class_hit(logic [4:0] code, logic [7:0] lit,
		logic [7:0] c, logic ci);
		logic up, lo, dg, an, gr, r, valid;
		logic [7:0] lit_lo, lit_up;
		up = (c >= 8'h41) && (c <= 8'h5A);
		lo = (c >= 8'h61) && (c <= 8'h7A);
		dg = (c >= 8'h30) && (c <= 8'h39);
		an = up || lo || dg;
		gr = (c >= 8'd33) && (c <= 8'd126);
		lit_lo = ((lit >= 8'h41) && (lit <= 8'h5A)) ? lit + 8'd32 : lit;
		lit_up = ((lit >= 8'h61) && (lit <= 8'h7A)) ? lit - 8'd32 : lit;
		valid = 1'b1;
		unique case (code[4:1])
			CLS_LITERAL: r = ci ? ((c == lit_lo) || (c == lit_up)) : (c == lit);
			CLS_ALNUM:   r = an;
			CLS_ALPHA:   r = up || lo;
			CLS_BLANK:   r = (c == 8'h20) || (c == 8'h09);
			CLS_CNTRL:   r = (c < 8'd32) || (c == 8'd127);
			CLS_DIGIT:   r = dg;
			CLS_GRAPH:   r = gr;
			CLS_PRINT:   r = (c >= 8'd32) && (c <= 8'd126);
			CLS_LOWER:   r = lo;
			CLS_UPPER:   r = up;
			CLS_LETTER:  r = lo || up;
			CLS_PUNCT:   r = gr && !an;
			CLS_SPACE:   r = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
			CLS_XDIGIT:  r = dg || ((c >= 8'h61) && (c <= 8'h66))
				|| ((c >= 8'h41) && (c <= 8'h46));
			CLS_ANY:     r = 1'b1;
			default: begin
				r = 1'b0;
				valid = 1'b0;
			end
		endcase
		return valid ? (r ^ code[0]) : 1'b0;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bscmr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bscmr_cell
// One position of the match chain: a window byte, a pattern entry and the
// class test between them. The window byte moves toward cell zero on shift.
// ----------------------------------------------------------------------------
module bscmr_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bscmr_pkg::cell_ctrl_t ctrl,
	input  wire logic                  win_we,
	input  wire logic                  pat_we,
	input  wire logic [7:0]            shift_in,
	output logic [7:0]                 win,
	output logic                       hit
);

	logic [7:0] win_q;
	logic [7:0] pbyte_q;
	logic [4:0] pclass_q;

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_q <= ctrl.wbyte;
		end else if (ctrl.shift) begin
			win_q <= shift_in;
		end
		if (pat_we) begin
			pbyte_q <= ctrl.pbyte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pclass_q <= '0;
		end else if (pat_we) begin
			pclass_q <= ctrl.pcode;
		end
	end

	assign win = win_q;
	assign hit = bscmr_pkg::class_hit(pclass_q, pbyte_q, win_q, ctrl.case_ins);

endmodule
`default_nettype wire

>>> hw/rtl/byte_stream_class_match_replace_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stream_class_match_replace_top
// Streaming pattern match and replace with character classes.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (in_valid/in_stall): data bytes, end of
// stream, pattern entry loads and replacement byte loads. Results leave on
// the output channel (out_valid/out_stall), one per transfer; last marks the
// final result of an item. Configuration is written on the cfg channel,
// which is always ready; the user must write it only while the block is
// idle, and the block itself does not enforce this. The window is a chain
// of PATTERN_MAX cells; every cell compares its window byte against its
// pattern entry in parallel, and each shift moves the window by one cell.
// A load writes its entry or is refused with an error result. A data byte
// goes through S_TEST, S_REG1, S_REG2, S_PASS for a passed byte, and S_UPD;
// a match adds S_REPORT and an S_REPL result per replacement byte. End of
// stream goes through the same tests, then S_FLUSH per flushed byte and
// S_END for the status. The output register lets the next item enter while
// a result waits. When the receiver stalls, the sequencer holds until the
// output register frees. Reset empties the window, clears the pattern
// classes, position count and found flag, and restores register defaults.
// ----------------------------------------------------------------------------
module byte_stream_class_match_replace_top #(
	parameter int PATTERN_MAX   = 32,
	parameter int POSITION_BITS = 48
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               cmd,
	input  wire logic [7:0]               data_byte,
	input  wire logic [4:0]               entry_index,
	input  wire logic [4:0]               class_code,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [1:0]                    kind,
	output logic [7:0]                    out_byte,
	output logic [POSITION_BITS-1:0]      match_position,
	output logic                          any_found,
	output logic                          last,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [2:0]               cfg_index,
	input  wire logic [POSITION_BITS-1:0] cfg_data
);

	localparam int FW = $clog2(PATTERN_MAX + 1);
	localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int PB = POSITION_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_ERR, S_TEST, S_REG1, S_REG2, S_REPORT, S_REPL, S_PASS,
		S_UPD, S_FLUSH, S_END
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [5:0]    plen_q, rlen_q;
	logic          rep_en_q, case_ins_q;
	logic [PB-1:0] region_first_q, region_length_q;

	// Item and sequencer registers.
	logic [1:0]    cmd_q;
	logic [7:0]    byte_q;
	logic [FW-1:0] fill_q, rcnt_q;
	logic [PB-1:0] count_q, pos_q, dist_q;
	logic          found_q, cand_q, after_first_q;

	logic [7:0] rep_q [PATTERN_MAX];

	// Output register.
	logic          ovalid_q;
	logic [1:0]    okind_q;
	logic [7:0]    obyte_q;
	logic [PB-1:0] opos_q;
	logic          oany_q, olast_q;

	logic                  accept, out_free, out_load, load_err;
	logic [FW-1:0]         eff_len, eff_rep, fill_mid;
	logic                  upd_write, all_hit;
	logic [PATTERN_MAX-1:0] hit, win_we, pat_we;
	logic [7:0]            win [PATTERN_MAX];
	bscmr_pkg::cell_ctrl_t ctrl;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !ovalid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// States that place a result into the output register when it is free.
	assign out_load = out_free && ((state_q == S_ERR) || (state_q == S_REPORT)
		|| (state_q == S_REPL) || (state_q == S_PASS) || (state_q == S_FLUSH)
		|| (state_q == S_END));

	assign load_err = (32'(entry_index) >= PATTERN_MAX)
		|| ((cmd == bscmr_pkg::CMD_PAT) && (class_code[4:1] > bscmr_pkg::CLS_ANY));

	assign eff_len = (plen_q == 6'd0) ? FW'(1)
		: ((32'(plen_q) > PATTERN_MAX) ? FW'(PATTERN_MAX) : FW'(plen_q));
	assign eff_rep = (32'(rlen_q) > PATTERN_MAX) ? FW'(PATTERN_MAX) : FW'(rlen_q);

	// Window update of a data byte: drop the oldest byte if the window is
	// full, then append the new byte if there is room.
	assign fill_mid  = (fill_q >= eff_len) ? fill_q - FW'(1) : fill_q;
	assign upd_write = (state_q == S_UPD) && (32'(fill_mid) < PATTERN_MAX);

	always_comb begin
		ctrl.shift    = ((state_q == S_UPD) && (fill_q >= eff_len))
			|| ((state_q == S_FLUSH) && out_free);
		ctrl.wbyte    = byte_q;
		ctrl.pbyte    = data_byte;
		ctrl.pcode    = class_code;
		ctrl.case_ins = case_ins_q;
	end

	always_comb begin
		all_hit = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			win_we[i] = upd_write && (32'(fill_mid) == i);
			pat_we[i] = accept && (cmd == bscmr_pkg::CMD_PAT) && !load_err
				&& (32'(entry_index) == i);
			if ((i < 32'(eff_len)) && !hit[i]) begin
				all_hit = 1'b0;
			end
		end
	end

	for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
		bscmr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.win_we   (win_we[g]),
			.pat_we   (pat_we[g]),
			.shift_in ((g == PATTERN_MAX - 1) ? 8'd0 : win[(g + 1) % PATTERN_MAX]),
			.win      (win[g]),
			.hit      (hit[g])
		);
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == bscmr_pkg::CMD_REP) && !load_err) begin
			rep_q[IW'(entry_index)] <= data_byte;
		end
		if (accept) begin
			cmd_q  <= cmd;
			byte_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q          <= 6'd1;
			rlen_q          <= 6'd0;
			rep_en_q        <= 1'b0;
			case_ins_q      <= 1'b0;
			region_first_q  <= '0;
			region_length_q <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bscmr_pkg::CFG_PATTERN_LENGTH:   plen_q <= cfg_data[5:0];
				bscmr_pkg::CFG_REPLACE_LENGTH:   rlen_q <= cfg_data[5:0];
				bscmr_pkg::CFG_REPLACE_ENABLE:   rep_en_q <= cfg_data[0];
				bscmr_pkg::CFG_CASE_INSENSITIVE: case_ins_q <= cfg_data[0];
				bscmr_pkg::CFG_REGION_FIRST:     region_first_q <= cfg_data;
				bscmr_pkg::CFG_REGION_LENGTH:    region_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			rcnt_q        <= '0;
			count_q       <= '0;
			pos_q         <= '0;
			dist_q        <= '0;
			found_q       <= 1'b0;
			cand_q        <= 1'b0;
			after_first_q <= 1'b0;
			ovalid_q      <= 1'b0;
			okind_q       <= bscmr_pkg::KIND_BYTE;
			obyte_q       <= '0;
			opos_q        <= '0;
			oany_q        <= 1'b0;
			olast_q       <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (cmd == bscmr_pkg::CMD_PAT || cmd == bscmr_pkg::CMD_REP) begin
							if (load_err) begin
								state_q <= S_ERR;
							end
						end else begin
							state_q <= S_TEST;
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						okind_q  <= bscmr_pkg::KIND_ERROR;
						obyte_q  <= '0;
						opos_q   <= '0;
						oany_q   <= 1'b0;
						olast_q  <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_TEST: begin
					cand_q  <= (fill_q >= eff_len) && all_hit && (count_q >= PB'(fill_q));
					pos_q   <= count_q - PB'(fill_q);
					state_q <= S_REG1;
				end
				S_REG1: begin
					after_first_q <= (pos_q >= region_first_q);
					dist_q        <= pos_q - region_first_q;
					state_q       <= S_REG2;
				end
				S_REG2: begin
					priority if (cand_q && after_first_q
						&& (({1'b0, dist_q} + (PB + 1)'(eff_len)) <= {1'b0, region_length_q}))
					begin
						state_q <= S_REPORT;
					end else if (cmd_q == bscmr_pkg::CMD_DATA) begin
						state_q <= (rep_en_q && (fill_q >= eff_len)) ? S_PASS : S_UPD;
					end else begin
						state_q <= (rep_en_q && (fill_q != '0)) ? S_FLUSH : S_END;
					end
				end
				S_REPORT: begin
					if (out_free) begin
						okind_q  <= bscmr_pkg::KIND_MATCH;
						obyte_q  <= '0;
						opos_q   <= pos_q;
						oany_q   <= 1'b0;
						olast_q  <= (cmd_q == bscmr_pkg::CMD_DATA)
							&& !(rep_en_q && (eff_rep != '0));
						found_q  <= 1'b1;
						fill_q   <= '0;
						rcnt_q   <= '0;
						priority if (rep_en_q && (eff_rep != '0)) begin
							state_q <= S_REPL;
						end else if (cmd_q == bscmr_pkg::CMD_DATA) begin
							state_q <= S_UPD;
						end else begin
							state_q <= S_END;
						end
					end
				end
				S_REPL: begin
					if (out_free) begin
						okind_q  <= bscmr_pkg::KIND_BYTE;
						obyte_q  <= rep_q[rcnt_q[IW-1:0]];
						opos_q   <= '0;
						oany_q   <= 1'b0;
						olast_q  <= (cmd_q == bscmr_pkg::CMD_DATA)
							&& (rcnt_q == eff_rep - FW'(1));
						rcnt_q   <= rcnt_q + FW'(1);
						if (rcnt_q == eff_rep - FW'(1)) begin
							state_q <= (cmd_q == bscmr_pkg::CMD_DATA) ? S_UPD : S_END;
						end
					end
				end
				S_PASS: begin
					if (out_free) begin
						okind_q  <= bscmr_pkg::KIND_BYTE;
						obyte_q  <= win[0];
						opos_q   <= '0;
						oany_q   <= 1'b0;
						olast_q  <= 1'b1;
						state_q  <= S_UPD;
					end
				end
				S_UPD: begin
					fill_q  <= upd_write ? fill_mid + FW'(1) : fill_mid;
					count_q <= count_q + PB'(1);
					state_q <= S_IDLE;
				end
				S_FLUSH: begin
					if (out_free) begin
						okind_q  <= bscmr_pkg::KIND_BYTE;
						obyte_q  <= win[0];
						opos_q   <= '0;
						oany_q   <= 1'b0;
						olast_q  <= 1'b0;
						fill_q   <= fill_q - FW'(1);
						if (fill_q == FW'(1)) begin
							state_q <= S_END;
						end
					end
				end
				S_END: begin
					if (out_free) begin
						okind_q  <= bscmr_pkg::KIND_END;
						obyte_q  <= '0;
						opos_q   <= '0;
						oany_q   <= found_q;
						olast_q  <= 1'b1;
						fill_q   <= '0;
						count_q  <= '0;
						found_q  <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = ovalid_q;
	assign kind           = okind_q;
	assign out_byte       = obyte_q;
	assign match_position = opos_q;
	assign any_found      = oany_q;
	assign last           = olast_q;

endmodule
`default_nettype wire

>>> tb/sv/byte_stream_class_match_replace_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_class_match_replace_top_tb
// Drives pattern loads, byte streams and register settings into the match
// and replace block and checks every result against an internal predictor.
// ----------------------------------------------------------------------------
module byte_stream_class_match_replace_top_tb;

	localparam int PMAX = 32;
	localparam int LIMIT = 600000;
	localparam int ITEMS = 220;
	localparam logic [47:0] POS_ALL = 48'hFFFF_FFFF_FFFF;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  obyte;
		logic [47:0] pos;
		logic        any;
		logic        fin;
	} result_t;

	class match_stream_predictor;
		logic [5:0]  pat_len_reg, rep_len_reg;
		bit          rep_on, fold_case;
		logic [47:0] reg_first, reg_span;
		logic [7:0]  win [PMAX];
		logic [7:0]  pat [PMAX];
		logic [4:0]  cls [PMAX];
		logic [7:0]  rep [PMAX];
		int          wstart, wfill;
		logic [47:0] count;
		bit          found;
		result_t     pending_results[$];
		int          errors;

		function new();
			pat_len_reg = 6'd1;
			rep_len_reg = 6'd0;
			rep_on = 1'b0;
			fold_case = 1'b0;
			reg_first = '0;
			reg_span = POS_ALL;
			foreach (cls[i]) cls[i] = 5'd0;
			wstart = 0;
			wfill = 0;
			count = '0;
			found = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [47:0] v);
			case (idx)
				bscmr_pkg::CFG_PATTERN_LENGTH:   pat_len_reg = v[5:0];
				bscmr_pkg::CFG_REPLACE_LENGTH:   rep_len_reg = v[5:0];
				bscmr_pkg::CFG_REPLACE_ENABLE:   rep_on = v[0];
				bscmr_pkg::CFG_CASE_INSENSITIVE: fold_case = v[0];
				bscmr_pkg::CFG_REGION_FIRST:     reg_first = v;
				bscmr_pkg::CFG_REGION_LENGTH:    reg_span = v;
				default: ;
			endcase
		endfunction

		function int used_len();
			if (pat_len_reg == 6'd0) return 1;
			return (pat_len_reg > PMAX) ? PMAX : int'(pat_len_reg);
		endfunction

		function int used_rep();
			return (rep_len_reg > PMAX) ? PMAX : int'(rep_len_reg);
		endfunction

		function bit in_class(logic [4:0] code, logic [7:0] lit, logic [7:0] c);
			bit hit, up, lo, dg, gr;
			logic [7:0] lc, uc;
			up = c inside {[8'h41:8'h5A]};
			lo = c inside {[8'h61:8'h7A]};
			dg = c inside {[8'h30:8'h39]};
			gr = c inside {[8'd33:8'd126]};
			case (code[4:1])
				bscmr_pkg::CLS_LITERAL: begin
					lc = (lit inside {[8'h41:8'h5A]}) ? lit + 8'd32 : lit;
					uc = (lit inside {[8'h61:8'h7A]}) ? lit - 8'd32 : lit;
					hit = fold_case ? (c == lc || c == uc) : (c == lit);
				end
				bscmr_pkg::CLS_ALNUM:  hit = up | lo | dg;
				bscmr_pkg::CLS_ALPHA:  hit = up | lo;
				bscmr_pkg::CLS_BLANK:  hit = (c == 8'h20) || (c == 8'h09);
				bscmr_pkg::CLS_CNTRL:  hit = (c < 8'd32) || (c == 8'd127);
				bscmr_pkg::CLS_DIGIT:  hit = dg;
				bscmr_pkg::CLS_GRAPH:  hit = gr;
				bscmr_pkg::CLS_PRINT:  hit = c inside {[8'd32:8'd126]};
				bscmr_pkg::CLS_LOWER:  hit = lo;
				bscmr_pkg::CLS_UPPER:  hit = up;
				bscmr_pkg::CLS_LETTER: hit = lo | up;
				bscmr_pkg::CLS_PUNCT:  hit = gr && !(up | lo | dg);
				bscmr_pkg::CLS_SPACE:  hit = (c == 8'h20) || (c inside {[8'd9:8'd13]});
				bscmr_pkg::CLS_XDIGIT: hit = dg || (c inside {[8'h61:8'h66]})
					|| (c inside {[8'h41:8'h46]});
				bscmr_pkg::CLS_ANY:    hit = 1'b1;
				default:               return 1'b0;
			endcase
			return hit ^ code[0];
		endfunction

		function void emit(logic [1:0] k, logic [7:0] b, logic [47:0] p, bit a);
			result_t r;
			r.kind = k;
			r.obyte = b;
			r.pos = p;
			r.any = a;
			r.fin = 1'b0;
			pending_results.push_back(r);
		endfunction

		function logic [7:0] win_at(int i);
			return win[(wstart + i) % PMAX];
		endfunction

		// Reports a match in region, emits the replacement if enabled and empties the window.
		function bit match_window();
			int L;
			longint unsigned p;
			L = used_len();
			if (wfill < L) return 1'b0;
			for (int i = 0; i < L; i++)
				if (!in_class(cls[i], pat[i], win_at(i))) return 1'b0;
			if (count < wfill) return 1'b0;
			p = count - wfill;
			if (p < reg_first || p + L - reg_first > reg_span) return 1'b0;
			emit(bscmr_pkg::KIND_MATCH, 8'd0, p[47:0], 1'b0);
			found = 1'b1;
			if (rep_on)
				for (int i = 0; i < used_rep(); i++)
					emit(bscmr_pkg::KIND_BYTE, rep[i], 48'd0, 1'b0);
			wfill = 0;
			wstart = 0;
			return 1'b1;
		endfunction

		function void take_item(logic [1:0] c, logic [7:0] b, logic [4:0] idx,
			logic [4:0] code);
			int n0;
			bit hit;
			n0 = pending_results.size();
			if (c == bscmr_pkg::CMD_PAT || c == bscmr_pkg::CMD_REP) begin
				if (c == bscmr_pkg::CMD_PAT && code[4:1] > bscmr_pkg::CLS_ANY) begin
					emit(bscmr_pkg::KIND_ERROR, 8'd0, 48'd0, 1'b0);
				end else if (c == bscmr_pkg::CMD_PAT) begin
					pat[idx] = b;
					cls[idx] = code;
				end else begin
					rep[idx] = b;
				end
			end else if (c == bscmr_pkg::CMD_DATA) begin
				hit = match_window();
				if (!hit && wfill >= used_len()) begin
					if (rep_on) emit(bscmr_pkg::KIND_BYTE, win[wstart], 48'd0, 1'b0);
					wstart = (wstart + 1) % PMAX;
					wfill--;
				end
				if (wfill < PMAX) begin
					win[(wstart + wfill) % PMAX] = b;
					wfill++;
				end
				count++;
			end else begin
				hit = match_window();
				if (rep_on)
					for (int i = 0; i < wfill; i++)
						emit(bscmr_pkg::KIND_BYTE, win_at(i), 48'd0, 1'b0);
				emit(bscmr_pkg::KIND_END, 8'd0, 48'd0, found);
				wstart = 0;
				wfill = 0;
				count = '0;
				found = 1'b0;
			end
			if (pending_results.size() > n0)
				pending_results[pending_results.size() - 1].fin = 1'b1;
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d", got.kind);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (got.kind !== e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, got.kind);
				errors++;
			end
			if (got.obyte !== e.obyte) begin
				$error("out_byte: expected %0h, got %0h", e.obyte, got.obyte);
				errors++;
			end
			if (got.pos !== e.pos) begin
				$error("match_position: expected %0d, got %0d", e.pos, got.pos);
				errors++;
			end
			if (got.any !== e.any) begin
				$error("any_found: expected %0d, got %0d", e.any, got.any);
				errors++;
			end
			if (got.fin !== e.fin) begin
				$error("last: expected %0d, got %0d", e.fin, got.fin);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_stall;
	logic [1:0]  cmd;
	logic [7:0]  data_byte;
	logic [4:0]  entry_index, class_code;
	logic        out_valid, out_stall;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [47:0] match_position;
	logic        any_found, last;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;

	byte_stream_class_match_replace_top dut (.*);

	match_stream_predictor model = new();
	int  items_taken = 0, regs_taken = 0, cycles = 0;
	bit  quiet = 0;
	int  stall_left = 0;
	logic [7:0] cur_pat [PMAX];
	logic [4:0] cur_cls [PMAX];

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		result_t r;
		cycles++;
		if (arst_n && in_valid && !in_stall) begin
			model.take_item(cmd, data_byte, entry_index, class_code);
			items_taken++;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			model.set_reg(cfg_index, cfg_data);
			regs_taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			r.kind = kind;
			r.obyte = out_byte;
			r.pos = match_position;
			r.any = any_found;
			r.fin = last;
			model.check_result(r);
		end
		if (cycles > LIMIT) begin
			$display("byte_stream_class_match_replace_top_tb: done, errors");
			$finish;
		end
	end

	// The receiver stalls in short random bursts.
	always @(negedge clk) begin
		if (quiet) begin
			out_stall = 1'b0;
		end else if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall = 1'b1;
			stall_left = $urandom_range(0, 6);
		end else begin
			out_stall = 1'b0;
		end
	end

	task automatic send(logic [1:0] c, logic [7:0] b, logic [4:0] idx, logic [4:0] code);
		int target;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid = 1'b1;
		cmd = c;
		data_byte = b;
		entry_index = idx;
		class_code = code;
		target = items_taken + 1;
		while (items_taken < target) @(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [47:0] v);
		int target;
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		target = regs_taken + 1;
		while (regs_taken < target) @(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Accepted loads produce no result, so a data byte may still be in flight.
	task automatic drain();
		while (model.pending_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_letter();
		logic [7:0] set [4] = '{8'h61, 8'h41, 8'h62, 8'h42};
		return set[$urandom_range(0, 3)];
	endfunction

	task automatic load_pattern(int L);
		logic [4:0] code;
		logic [7:0] b;
		for (int i = 0; i < L; i++) begin
			b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_letter();
			code = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(0, 29));
			cur_pat[i] = b;
			cur_cls[i] = code;
			send(bscmr_pkg::CMD_PAT, b, 5'(i), code);
		end
	endtask

	// Sends bytes meant to satisfy the loaded pattern, position by position.
	task automatic send_instance(int L);
		logic [7:0] b;
		for (int i = 0; i < L; i++) begin
			if (cur_cls[i] == 5'd0) begin
				b = cur_pat[i];
				if (model.fold_case && $urandom_range(0, 1)) b = b ^ 8'h20;
			end else begin
				b = 8'($urandom);
				for (int t = 0; t < 60 && !model.in_class(cur_cls[i], cur_pat[i], b); t++)
					b = 8'($urandom);
			end
			send(bscmr_pkg::CMD_DATA, b, 5'($urandom), 5'($urandom));
		end
	endtask

	function automatic logic [47:0] wide_rand();
		return {16'($urandom), 32'($urandom)};
	endfunction

	initial begin
		logic [47:0] first, span;
		logic [5:0] plen, rlen;
		int L;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = bscmr_pkg::CMD_DATA;
		data_byte = 8'd0;
		entry_index = 5'd0;
		class_code = 5'd0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = bscmr_pkg::CFG_PATTERN_LENGTH;
		cfg_data = 48'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every pattern and replacement entry is written before any byte is streamed.
		for (int i = 0; i < PMAX; i++) begin
			cur_pat[i] = pick_letter();
			cur_cls[i] = 5'd0;
			send(bscmr_pkg::CMD_PAT, cur_pat[i], 5'(i), 5'd0);
			send(bscmr_pkg::CMD_REP, 8'($urandom), 5'(i), 5'($urandom));
		end

		// Directed: refused classes, byte extremes, an empty stream, defaults.
		send(bscmr_pkg::CMD_PAT, 8'hFF, 5'd31, 5'd30);
		send(bscmr_pkg::CMD_PAT, 8'h00, 5'd0, 5'd31);
		send(bscmr_pkg::CMD_END, 8'd0, 5'd0, 5'd0);
		send(bscmr_pkg::CMD_DATA, 8'h00, 5'd0, 5'd0);
		send(bscmr_pkg::CMD_DATA, 8'hFF, 5'd31, 5'd31);
		send(bscmr_pkg::CMD_DATA, cur_pat[0], 5'd0, 5'd0);
		send(bscmr_pkg::CMD_DATA, cur_pat[0] ^ 8'h20, 5'd0, 5'd0);
		send(bscmr_pkg::CMD_END, 8'd0, 5'd0, 5'd0);
		drain();
		write_reg(bscmr_pkg::CFG_REPLACE_ENABLE, 48'd1);
		write_reg(bscmr_pkg::CFG_CASE_INSENSITIVE, 48'd1);
		write_reg(bscmr_pkg::CFG_REPLACE_LENGTH, 48'd63);
		write_reg(bscmr_pkg::CFG_PATTERN_LENGTH, 48'd0);
		send(bscmr_pkg::CMD_DATA, cur_pat[0] ^ 8'h20, 5'd0, 5'd0);
		send(bscmr_pkg::CMD_DATA, 8'h7A, 5'd0, 5'd0);
		send(bscmr_pkg::CMD_DATA, cur_pat[0], 5'd0, 5'd0);
		send(bscmr_pkg::CMD_END, 8'd0, 5'd0, 5'd0);
		drain();
		write_reg(bscmr_pkg::CFG_PATTERN_LENGTH, 48'd63);
		load_pattern(PMAX);
		send_instance(PMAX);
		send(bscmr_pkg::CMD_END, 8'd0, 5'd0, 5'd0);

		while (items_taken < ITEMS) begin
			drain();
			quiet = (items_taken > ITEMS - 40);
			case ($urandom_range(0, 5))
				0: plen = 6'd0;
				1: plen = 6'd63;
				2: plen = 6'($urandom_range(9, 32));
				default: plen = 6'($urandom_range(1, 5));
			endcase
			case ($urandom_range(0, 3))
				0: rlen = 6'd0;
				1: rlen = 6'($urandom_range(33, 63));
				default: rlen = 6'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 5))
				0: begin first = POS_ALL; span = POS_ALL; end
				1: begin first = 48'd0; span = 48'd0; end
				2: begin first = wide_rand(); span = wide_rand(); end
				3: begin first = 48'($urandom_range(0, 20)); span = 48'($urandom_range(0, 30)); end
				default: begin first = 48'd0; span = POS_ALL; end
			endcase
			write_reg(bscmr_pkg::CFG_PATTERN_LENGTH, 48'(plen));
			write_reg(bscmr_pkg::CFG_REPLACE_LENGTH, 48'(rlen));
			write_reg(bscmr_pkg::CFG_REPLACE_ENABLE, 48'($urandom_range(0, 1)));
			write_reg(bscmr_pkg::CFG_CASE_INSENSITIVE, 48'($urandom_range(0, 1)));
			write_reg(bscmr_pkg::CFG_REGION_FIRST, first);
			write_reg(bscmr_pkg::CFG_REGION_LENGTH, span);
			L = model.used_len();
			if ($urandom_range(0, 2) != 0 && items_taken + L < ITEMS) load_pattern(L);
			for (int r = 0; r < 4; r++)
				send(bscmr_pkg::CMD_REP, 8'($urandom), 5'($urandom), 5'($urandom));
			if ($urandom_range(0, 4) == 0)
				send(bscmr_pkg::CMD_PAT, 8'($urandom), 5'($urandom),
					5'($urandom_range(30, 31)));
			for (int s = 0; s < 6 && items_taken < ITEMS; s++) begin
				if ($urandom_range(0, 2) != 0) begin
					send_instance(L);
				end else begin
					repeat ($urandom_range(1, 3)) begin
						send(bscmr_pkg::CMD_DATA,
							($urandom_range(0, 1) ? pick_letter() : 8'($urandom)),
							5'($urandom), 5'($urandom));
					end
				end
			end
			// Leaving the stream open lets the next setting meet a filled window.
			if ($urandom_range(0, 1)) begin
				send(bscmr_pkg::CMD_END, 8'($urandom), 5'($urandom), 5'($urandom));
			end
		end
		send(bscmr_pkg::CMD_END, 8'd0, 5'd0, 5'd0);
		drain();
		if (model.errors == 0 && model.pending_results.size() == 0) begin
			$display("byte_stream_class_match_replace_top_tb: done, clean");
		end else begin
			$display("byte_stream_class_match_replace_top_tb: done, errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/bscmr_pkg.sv
hw/rtl/bscmr_cell.sv
hw/rtl/byte_stream_class_match_replace_top.sv
tb/sv/byte_stream_class_match_replace_top_tb.sv
